// ----- design/tdc_pkg.sv -----
// Package: payload word types and register indexes for the dispense channel controller.
`default_nettype none

package tdc_pkg;

  localparam int unsigned CHAN_W = 2;
  localparam int unsigned ECHO_W = 20;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POUR_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COOLOFF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACT_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACT_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAR       = 3'd5;

  // Register reset values
  localparam logic [TIME_W-1:0] POUR_TIME_RST = 32'd5000;
  localparam logic [TIME_W-1:0] COOLOFF_RST   = 32'd3000;
  localparam logic [ECHO_W-1:0] ACT_LOW_RST   = 20'd117;
  localparam logic [ECHO_W-1:0] ACT_HIGH_RST  = 20'd875;
  localparam logic [ECHO_W-1:0] SAFE_RST      = 20'd1166;
  localparam logic [ECHO_W-1:0] FAR_RST       = 20'd23324;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [ECHO_W-1:0] echo_us;
    logic [TIME_W-1:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_chan;
    logic              drive_on;
    logic              hand_latched;
    logic              turned_on;
    logic              turned_off;
  } out_word_t;

endpackage

`default_nettype wire

// ----- design/touchless_dispense_channel_ctrl.sv -----
// Top level: multi-channel touchless dispense controller, one echo word in, one status word out.
// Pipeline: a word accepted sits in the input register, and its result is loaded into the
// output register when that register is free or being drained, which raises out_valid.
// Throughput: one word per cycle while the output is not stalled; the per-channel state update
// and the two 32-bit time differences are combinational between the input and output registers.
// Reset (rst, synchronous): all channels off and unlatched, stop and start times zero,
// configuration registers back to their defaults, both pipeline registers empty.
`default_nettype none

module touchless_dispense_channel_ctrl #(
  parameter int unsigned CHANNELS = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // echo words
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire tdc_pkg::in_word_t              in_data,
  // status words
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      tdc_pkg::out_word_t             out_data,
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [tdc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [tdc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import tdc_pkg::*;

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers
  logic [TIME_W-1:0] pour_time_ms;
  logic [TIME_W-1:0] cooloff_ms;
  logic [ECHO_W-1:0] act_low_echo_us;
  logic [ECHO_W-1:0] act_high_echo_us;
  logic [ECHO_W-1:0] safe_echo_us;
  logic [ECHO_W-1:0] far_echo_us;

  // Per-channel state
  logic [CHANNELS-1:0] drive_state;
  logic [CHANNELS-1:0] hand_state;
  logic [TIME_W-1:0]   last_stop_ms  [CHANNELS];
  logic [TIME_W-1:0]   pour_start_ms [CHANNELS];

  // Input register
  logic     in_held;
  in_word_t in_q;

  // Stage controls
  logic advance;

  // Step logic
  logic              chan_ok;
  logic [IDX_W-1:0]  idx;
  logic              d0;
  logic              h0;
  logic [TIME_W-1:0] pour_age;
  logic [TIME_W-1:0] stop_age;
  logic              timeout;
  logic              d1;
  logic              in_window;
  logic              activate;
  logic              release_hit;
  logic              d2;
  logic              h1;
  logic              withdraw;
  logic              drive_next;
  logic              hand_next;
  logic              stop_evt;
  out_word_t         out_next;

  // Advance the held word whenever the output register is empty or being drained.
  assign advance  = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      pour_time_ms     <= POUR_TIME_RST;
      cooloff_ms       <= COOLOFF_RST;
      act_low_echo_us  <= ACT_LOW_RST;
      act_high_echo_us <= ACT_HIGH_RST;
      safe_echo_us     <= SAFE_RST;
      far_echo_us      <= FAR_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_POUR_TIME: pour_time_ms     <= cfg_wdata[TIME_W-1:0];
        REG_COOLOFF:   cooloff_ms       <= cfg_wdata[TIME_W-1:0];
        REG_ACT_LOW:   act_low_echo_us  <= cfg_wdata[ECHO_W-1:0];
        REG_ACT_HIGH:  act_high_echo_us <= cfg_wdata[ECHO_W-1:0];
        REG_SAFE:      safe_echo_us     <= cfg_wdata[ECHO_W-1:0];
        REG_FAR:       far_echo_us      <= cfg_wdata[ECHO_W-1:0];
        default: ;
      endcase
    end
  end

  // One step for the held word. The state read here already reflects the word just
  // ahead of it, because state is written on the same edge that word left this stage.
  always_comb begin
    chan_ok = (32'(in_q.chan) < CHANNELS);
    idx     = IDX_W'(in_q.chan);
    d0      = drive_state[idx];
    h0      = hand_state[idx];

    // Timeout: a pour that has run its full time stops first.
    pour_age = in_q.now_ms - pour_start_ms[idx];
    timeout  = d0 && (pour_age >= pour_time_ms);
    d1       = d0 && !timeout;

    // A stop in this very step restarts the cool-off at zero elapsed time.
    stop_age = timeout ? '0 : (in_q.now_ms - last_stop_ms[idx]);

    // Activation window: low bound exclusive, high bound inclusive.
    in_window = (in_q.echo_us > act_low_echo_us) && (in_q.echo_us <= act_high_echo_us);
    activate  = in_window && !d1 && !h0 && (stop_age >= cooloff_ms);

    // Release band only applies when the echo is outside the activation window.
    release_hit = !in_window && (in_q.echo_us >= safe_echo_us) &&
                  (in_q.echo_us < far_echo_us) && d1;

    d2 = activate || (d1 && !release_hit);
    h1 = h0 || activate;

    // Withdrawal: hand far enough away drops the latch and any pour.
    withdraw   = h1 && (in_q.echo_us >= safe_echo_us);
    hand_next  = h1 && !withdraw;
    drive_next = d2 && !withdraw;
    stop_evt   = timeout || release_hit || (withdraw && d2);

    out_next.out_chan     = in_q.chan;
    out_next.drive_on     = chan_ok && drive_next;
    out_next.hand_latched = chan_ok && hand_next;
    out_next.turned_on    = chan_ok && activate;
    out_next.turned_off   = chan_ok && stop_evt;
  end

  // Per-channel state update; an out-of-range channel leaves everything untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_state <= '0;
      hand_state  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_stop_ms[i]  <= '0;
        pour_start_ms[i] <= '0;
      end
    end else if (advance && chan_ok) begin
      drive_state[idx] <= drive_next;
      hand_state[idx]  <= hand_next;
      if (stop_evt) begin
        last_stop_ms[idx] <= in_q.now_ms;
      end
      if (activate) begin
        pour_start_ms[idx] <= in_q.now_ms;
      end
    end
  end

  // Output register: hold until taken, load when the held word advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= out_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/tdc_checker.sv -----
// Checker: port-level properties of the dispense controller, bound to the top level.
`default_nettype none

module tdc_checker #(
  parameter int unsigned CHANNELS = 4
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire tdc_pkg::out_word_t out_data
);

  import tdc_pkg::*;

  // A stalled status word holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("status word changed while stalled");

  // Drive on always comes with a latched hand.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_on |-> out_data.hand_latched)
    else $error("drive on without hand latch");

  // A start not undone in the same step leaves the drive on; a lone stop leaves it off.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.turned_on != out_data.turned_off) |->
      (out_data.drive_on == out_data.turned_on))
    else $error("event flags disagree with drive level");

  // An unknown channel reports nothing.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (32'(out_data.out_chan) >= CHANNELS) |->
      !out_data.drive_on && !out_data.hand_latched &&
      !out_data.turned_on && !out_data.turned_off)
    else $error("activity reported on an unknown channel");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("status word valid after reset");

endmodule

bind touchless_dispense_channel_ctrl tdc_checker #(.CHANNELS(CHANNELS)) u_tdc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
